/* hw/rtl/spsp_pkg.sv */
`timescale 1ns / 1ps

package spsp_pkg;

   // Syntax positions
   localparam logic [4:0] POS_HDR    = 5'd0;
   localparam logic [4:0] POS_PROF   = 5'd2;
   localparam logic [4:0] POS_POCT   = 5'd9;
   localparam logic [4:0] POS_LSB    = 5'd10;
   localparam logic [4:0] POS_DPOAZ  = 5'd11;
   localparam logic [4:0] POS_NREFC  = 5'd14;
   localparam logic [4:0] POS_OFFREF = 5'd15;
   localparam logic [4:0] POS_NREF   = 5'd16;
   localparam logic [4:0] POS_FMBS   = 5'd20;
   localparam logic [4:0] POS_MBAFF  = 5'd21;
   localparam logic [4:0] POS_D8X8   = 5'd22;
   localparam logic [4:0] POS_VUI    = 5'd23;
   localparam logic [4:0] POS_STOP   = 5'd24;
   localparam logic [4:0] POS_ALIGN  = 5'd25;
   localparam logic [4:0] POS_DONE   = 5'd26;
   localparam logic [4:0] POS_NOSTOP = 5'd27;
   localparam logic [4:0] POS_OVF    = 5'd28;
   localparam logic [4:0] POS_VUIUNS = 5'd29;

   // Element numbers
   localparam logic [4:0] ID_REF_IDC   = 5'd0;
   localparam logic [4:0] ID_UNIT_TYPE = 5'd1;
   localparam logic [4:0] ID_STATUS    = 5'd23;

   // Final status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NO_STOP  = 3'd1;
   localparam logic [2:0] ST_RAN_OUT  = 3'd2;
   localparam logic [2:0] ST_UE_OVF   = 3'd3;
   localparam logic [2:0] ST_VUI_UNS  = 3'd4;

   localparam logic [7:0] MAX_REF_CYCLE = 8'd255;

   // Byte queue geometry
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       hdr;
   } qentry_type;

   // Fixed field width in bits, zero for Exp-Golomb fields
   function automatic logic [3:0] field_width(input logic [4:0] p);
      logic [3:0] w;
      case (p)
         5'd2, 5'd3: w = 4'd8;
         5'd4, 5'd5, 5'd6, 5'd11, 5'd17, 5'd20, 5'd21, 5'd22, 5'd23: w = 4'd1;
         default: w = 4'd0;
      endcase
      return w;
   endfunction

   function automatic logic field_signed(input logic [4:0] p);
      return (p == 5'd12) || (p == 5'd13) || (p == 5'd15);
   endfunction

endpackage

/* hw/rtl/sequence_parameter_set_parser_core.sv */
`timescale 1ns / 1ps
// Parses one H.264 sequence parameter set NAL unit (emulation bytes already
// removed). The unit arrives as byte beats on req_ and leaves as one element beat
// per decoded syntax field (the VUI flag apart) on rsp_. A status beat (element
// 23, tlast high) closes the unit on the beat marked req_tlast. The Exp-Golomb
// decoder consumes one bit per cycle while the output is free. It fetches a byte
// from its idle state for the first byte after the header and for any byte that
// arrives after the byte queue has run empty; otherwise it takes the next byte as
// it finishes the current one. The status beat follows the last byte. A four-beat
// queue lets input beats be taken while the decoder or the output is busy. A
// stalled result holds the decoder. VUI parameters are not parsed.

module sequence_parameter_set_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [4:0] element_id, [37:5] element_value,
                                    // [40:38] status, [47:41] zero
   output logic        rsp_tlast    // last_result
);

   spsp_pkg::qentry_type push_entry, pop_entry;
   logic q_push, q_full, q_pop, q_valid;
   logic [4:0]  rsp_id;
   logic [32:0] rsp_value;
   logic [2:0]  rsp_status;

   spsp_front u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .q_full(q_full), .q_push(q_push), .q_entry(push_entry)
   );

   spsp_queue u_queue (
      .clock(clock), .reset(reset),
      .push(q_push), .wr_entry(push_entry), .full(q_full),
      .pop(q_pop), .rd_valid(q_valid), .rd_entry(pop_entry)
   );

   spsp_back u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_entry(pop_entry), .q_pop(q_pop),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_id(rsp_id), .rsp_value(rsp_value), .rsp_status(rsp_status),
      .rsp_last(rsp_tlast)
   );

   assign rsp_tdata = {7'd0, rsp_status, rsp_value, rsp_id};

endmodule

/* hw/rtl/spsp_front.sv */
`timescale 1ns / 1ps

module spsp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tlast,
   input  logic                  q_full,
   output logic                  q_push,
   output spsp_pkg::qentry_type  q_entry
);

   logic hdr_ff, hdr_in;

   // Take a beat whenever the queue has room
   assign req_tready   = !q_full;
   assign q_push       = req_tvalid && !q_full;
   assign q_entry.data = req_tdata;
   assign q_entry.last = req_tlast;
   assign q_entry.hdr  = hdr_ff;

   // The beat after a last beat opens a new unit
   always_comb begin
      hdr_in = hdr_ff;
      if (q_push) hdr_in = req_tlast;
   end

   always_ff @(posedge clock) begin
      if (reset) hdr_ff <= 1'b1;
      else       hdr_ff <= hdr_in;
   end

endmodule

/* hw/rtl/spsp_queue.sv */
`timescale 1ns / 1ps

module spsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  spsp_pkg::qentry_type  wr_entry,
   output logic                  full,
   input  logic                  pop,
   output logic                  rd_valid,
   output spsp_pkg::qentry_type  rd_entry
);

   spsp_pkg::qentry_type mem_ff [spsp_pkg::QDEPTH];
   logic [spsp_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [spsp_pkg::QPTR_W:0]   count_ff, count_in;

   assign full     = (count_ff == (spsp_pkg::QPTR_W+1)'(spsp_pkg::QDEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_entry = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff + (spsp_pkg::QPTR_W)'(push);
      rd_ptr_in = rd_ptr_ff + (spsp_pkg::QPTR_W)'(pop);
      count_in  = count_ff + (spsp_pkg::QPTR_W+1)'(push) - (spsp_pkg::QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= wr_entry;
   end

endmodule

/* hw/rtl/spsp_back.sv */
`timescale 1ns / 1ps

module spsp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  spsp_pkg::qentry_type  q_entry,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [4:0]            rsp_id,
   output logic [32:0]           rsp_value,
   output logic [2:0]            rsp_status,
   output logic                  rsp_last
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_HDR  = 4'b0010,
      S_BITS = 4'b0100,
      S_STAT = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [4:0]  pos_ff, pos_in;
   logic [5:0]  lz_ff, lz_in;
   logic [32:0] acc_ff, acc_in;
   logic [3:0]  fbl_ff, fbl_in;
   logic [7:0]  loop_ff, loop_in;
   logic        suf_ff, suf_in;
   logic        vld_ff, vld_in;
   logic [4:0]  id_ff, id_in;
   logic [32:0] val_ff, val_in;
   logic [2:0]  st_ff, st_in;
   logic        lr_ff, lr_in;

   assign rsp_tvalid = vld_ff;
   assign rsp_id     = id_ff;
   assign rsp_value  = val_ff;
   assign rsp_status = st_ff;
   assign rsp_last   = lr_ff;

   always_comb begin
      logic        out_free;
      logic        bitv;
      logic        fin;
      logic [32:0] fv;
      logic [32:0] shifted;
      logic [3:0]  fbl_dec;
      logic [5:0]  lz_inc;
      logic [7:0]  lc;
      logic [4:0]  nxt;

      out_free = !vld_ff || rsp_tready;
      state_in = state_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      cnt_in   = cnt_ff;
      pos_in   = pos_ff;
      lz_in    = lz_ff;
      acc_in   = acc_ff;
      fbl_in   = fbl_ff;
      loop_in  = loop_ff;
      suf_in   = suf_ff;
      q_pop    = 1'b0;
      vld_in   = vld_ff && !rsp_tready;
      id_in    = id_ff;
      val_in   = val_ff;
      st_in    = st_ff;
      lr_in    = lr_ff;
      bitv     = byte_ff[3'd7 - cnt_ff];
      fin      = 1'b0;
      fv       = '0;
      shifted  = {acc_ff[31:0], bitv};
      fbl_dec  = fbl_ff - 4'd1;
      lz_inc   = lz_ff + 6'd1;
      lc       = loop_ff;
      nxt      = pos_ff + 5'd1;

      case (state_ff)
         // Pull the next byte from the queue; a header byte also emits ref_idc
         S_IDLE: begin
            if (q_valid && out_free) begin
               q_pop   = 1'b1;
               byte_in = q_entry.data;
               last_in = q_entry.last;
               cnt_in  = '0;
               if (q_entry.hdr) begin
                  vld_in   = 1'b1;
                  id_in    = spsp_pkg::ID_REF_IDC;
                  val_in   = {31'd0, q_entry.data[6:5]};
                  st_in    = spsp_pkg::ST_OK;
                  lr_in    = 1'b0;
                  state_in = S_HDR;
               end else begin
                  state_in = S_BITS;
               end
            end
         end
         // Emit unit type, then start on profile, or go to status if the header was the last byte
         S_HDR: begin
            if (out_free) begin
               vld_in   = 1'b1;
               id_in    = spsp_pkg::ID_UNIT_TYPE;
               val_in   = {28'd0, byte_ff[4:0]};
               st_in    = spsp_pkg::ST_OK;
               lr_in    = 1'b0;
               pos_in   = spsp_pkg::POS_PROF;
               acc_in   = '0;
               lz_in    = '0;
               suf_in   = 1'b0;
               fbl_in   = spsp_pkg::field_width(spsp_pkg::POS_PROF);
               cnt_in   = '0;
               state_in = last_ff ? S_STAT : S_IDLE;
            end
         end
         // One bit a cycle while the output is free
         S_BITS: begin
            if (out_free) begin
               cnt_in = cnt_ff + 3'd1;
               if (pos_ff >= spsp_pkg::POS_DONE || pos_ff == spsp_pkg::POS_HDR) begin
                  // ignore trailing bytes
               end else if (pos_ff == spsp_pkg::POS_STOP) begin
                  if (!bitv)              pos_in = spsp_pkg::POS_NOSTOP;
                  else if (cnt_ff == 3'd7) pos_in = spsp_pkg::POS_DONE;
                  else                    pos_in = spsp_pkg::POS_ALIGN;
               end else if (pos_ff == spsp_pkg::POS_ALIGN) begin
                  if (bitv)               pos_in = spsp_pkg::POS_NOSTOP;
                  else if (cnt_ff == 3'd7) pos_in = spsp_pkg::POS_DONE;
               end else if (spsp_pkg::field_width(pos_ff) != 4'd0) begin
                  acc_in = shifted;
                  fbl_in = fbl_dec;
                  if (fbl_dec == 4'd0) begin
                     fin = 1'b1;
                     fv  = shifted;
                  end
               end else if (!suf_ff) begin
                  if (!bitv) begin
                     lz_in = lz_inc;
                     if (lz_inc >= 6'd32) pos_in = spsp_pkg::POS_OVF;
                  end else if (lz_ff == 6'd0) begin
                     fin = 1'b1;
                     fv  = '0;
                  end else begin
                     suf_in = 1'b1;
                     acc_in = 33'd1;
                  end
               end else begin
                  acc_in = shifted;
                  lz_in  = lz_ff - 6'd1;
                  if (lz_ff == 6'd1) begin
                     fin = 1'b1;
                     fv  = shifted - 33'd1;
                  end
               end

               // Field complete: emit it unless it is the VUI flag, and pick the next element
               if (fin) begin
                  if (pos_ff != spsp_pkg::POS_VUI) begin
                     vld_in = 1'b1;
                     id_in  = pos_ff;
                     st_in  = spsp_pkg::ST_OK;
                     lr_in  = 1'b0;
                     if (spsp_pkg::field_signed(pos_ff))
                        val_in = fv[0] ? ((fv + 33'd1) >> 1) : (33'd0 - (fv >> 1));
                     else
                        val_in = fv;
                  end
                  case (pos_ff)
                     spsp_pkg::POS_POCT: begin
                        if (fv == 33'd0)      nxt = spsp_pkg::POS_LSB;
                        else if (fv == 33'd1) nxt = spsp_pkg::POS_DPOAZ;
                        else                  nxt = spsp_pkg::POS_NREF;
                     end
                     spsp_pkg::POS_LSB: nxt = spsp_pkg::POS_NREF;
                     spsp_pkg::POS_NREFC, spsp_pkg::POS_OFFREF: begin
                        if (pos_ff == spsp_pkg::POS_NREFC)
                           lc = (fv > {25'd0, spsp_pkg::MAX_REF_CYCLE}) ?
                                spsp_pkg::MAX_REF_CYCLE : fv[7:0];
                        else
                           lc = loop_ff - 8'd1;
                        loop_in = lc;
                        nxt = (lc == 8'd0) ? spsp_pkg::POS_NREF : spsp_pkg::POS_OFFREF;
                     end
                     spsp_pkg::POS_FMBS:
                        nxt = fv[0] ? spsp_pkg::POS_D8X8 : spsp_pkg::POS_MBAFF;
                     spsp_pkg::POS_VUI:
                        nxt = (fv != 33'd0) ? spsp_pkg::POS_VUIUNS : spsp_pkg::POS_STOP;
                     default: nxt = pos_ff + 5'd1;
                  endcase
                  pos_in = nxt;
                  acc_in = '0;
                  lz_in  = '0;
                  suf_in = 1'b0;
                  fbl_in = spsp_pkg::field_width(nxt);
               end

               // End of byte: status, next byte, or wait
               if (cnt_ff == 3'd7) begin
                  if (last_ff) begin
                     state_in = S_STAT;
                  end else if (q_valid && !q_entry.hdr) begin
                     q_pop   = 1'b1;
                     byte_in = q_entry.data;
                     last_in = q_entry.last;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         // Final status, then back to reset state
         S_STAT: begin
            if (out_free) begin
               vld_in = 1'b1;
               id_in  = spsp_pkg::ID_STATUS;
               lr_in  = 1'b1;
               val_in = (pos_ff == spsp_pkg::POS_VUIUNS) ? 33'd1 : 33'd0;
               case (pos_ff)
                  spsp_pkg::POS_DONE:   st_in = spsp_pkg::ST_OK;
                  spsp_pkg::POS_NOSTOP: st_in = spsp_pkg::ST_NO_STOP;
                  spsp_pkg::POS_OVF:    st_in = spsp_pkg::ST_UE_OVF;
                  spsp_pkg::POS_VUIUNS: st_in = spsp_pkg::ST_VUI_UNS;
                  default:              st_in = spsp_pkg::ST_RAN_OUT;
               endcase
               pos_in   = spsp_pkg::POS_HDR;
               acc_in   = '0;
               lz_in    = '0;
               suf_in   = 1'b0;
               fbl_in   = '0;
               loop_in  = '0;
               cnt_in   = '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         pos_ff   <= spsp_pkg::POS_HDR;
         lz_ff    <= '0;
         acc_ff   <= '0;
         fbl_ff   <= '0;
         loop_ff  <= '0;
         suf_ff   <= 1'b0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pos_ff   <= pos_in;
         lz_ff    <= lz_in;
         acc_ff   <= acc_in;
         fbl_ff   <= fbl_in;
         loop_ff  <= loop_in;
         suf_ff   <= suf_in;
         vld_ff   <= vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      id_ff   <= id_in;
      val_ff  <= val_in;
      st_ff   <= st_in;
      lr_ff   <= lr_in;
   end

endmodule

/* hw/rtl/spsp_checker.sv */
`timescale 1ns / 1ps

module spsp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A stalled result beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   // tlast marks exactly the status element
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[4:0] == spsp_pkg::ID_STATUS)))
      else $error("tlast and status element disagree");

   // Field beats carry status ok
   a_field_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[40:38] == spsp_pkg::ST_OK)
      else $error("field beat with non-zero status");

   // Status beat value is the vui flag, set only for vui unsupported
   a_vui: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |->
         (rsp_tdata[37:5] == 33'd1) == (rsp_tdata[40:38] == spsp_pkg::ST_VUI_UNS))
      else $error("status beat value mismatch");

endmodule

bind sequence_parameter_set_parser_core spsp_checker u_spsp_checker (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
);
